// File: hdl/ipapc_pkg.sv
// Package: shared types and constants for the IP address policy check core.
`timescale 1ns / 1ps
package ipapc_pkg;

  // Widths of the ports and rule registers
  localparam int unsigned ModeW   = 2;
  localparam int unsigned V4W     = 32;
  localparam int unsigned V6HalfW = 64;
  localparam int unsigned KindW   = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 64;

  // Address family codes
  localparam logic [ModeW-1:0] MODE_V4 = 2'd0;
  localparam logic [ModeW-1:0] MODE_V6 = 2'd1;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_RULE_KIND = 2'd0,
    CFG_RULE_V4   = 2'd1,
    CFG_RULE_V6HI = 2'd2,
    CFG_RULE_V6LO = 2'd3
  } cfg_idx_e;

  // Rule kinds; codes 5 to 7 behave as public only
  typedef enum logic [KindW-1:0] {
    KIND_EXACT_V4 = 3'd0,
    KIND_EXACT_V6 = 3'd1,
    KIND_LOOPBACK = 3'd2,
    KIND_PUBLIC   = 3'd3,
    KIND_PRIVATE  = 3'd4
  } rule_kind_e;

  // IPv4 prefix constants
  localparam logic [V4W-1:0] V4_NET_LOOP   = 32'h7f00_0000;
  localparam logic [V4W-1:0] V4_NET_ZERO   = 32'h0000_0000;
  localparam logic [V4W-1:0] V4_NET_CGNAT  = 32'h6440_0000;
  localparam logic [V4W-1:0] V4_NET_LINK   = 32'ha9fe_0000;
  localparam logic [V4W-1:0] V4_NET_BENCH  = 32'hc612_0000;
  localparam logic [V4W-1:0] V4_NET_MCAST  = 32'he000_0000;
  localparam logic [V4W-1:0] V4_NET_TEN    = 32'h0a00_0000;
  localparam logic [V4W-1:0] V4_NET_172    = 32'hac10_0000;
  localparam logic [V4W-1:0] V4_NET_192    = 32'hc0a8_0000;

  // IPv6 leading-bit patterns
  localparam logic [7:0] V6_MCAST_B0 = 8'hff;
  localparam logic [9:0] V6_LINK_TOP = 10'h3fa;  // fe80::/10
  localparam logic [6:0] V6_ULA_TOP  = 7'h7e;    // fc00::/7
  localparam logic [2:0] V6_GUA_TOP  = 3'b001;   // 2000::/3
  localparam logic [31:0] V6_MAP_TAG = 32'h0000_ffff;

  // Address class flags handed from the classify stage to the decide stage
  typedef struct packed {
    logic is_v4;
    logic is_v6;
    logic v4_eq;        // IPv4 equals rule address
    logic v4_loop;
    logic v4_ok_priv;   // IPv4 not hard-blocked
    logic v4_pub;
    logic v6_eq;        // all 128 bits equal rule address
    logic v6_map_eq;    // mapped form of the rule IPv4 address
    logic v6_loop;
    logic v6_ok_priv;
    logic v6_pub;
  } addr_flags_t;

endpackage

// File: hdl/ip_address_policy_check_core.sv
// Top level: three-stage pipelined IP address policy check.
//
//  channel   ports                                            handshake
//  request   start_i, mode_i, ipv4_address_i, ipv6_high/low_i  start_i & !busy_o
//  result    done_o, allowed_o                                 done_o strobe, 1 cycle
//  config    cfg_we_i, cfg_idx_i, cfg_data_i                   cfg_we_i
//
// A word is taken every cycle; busy_o stays low. The decision passes through
// the input register, the class flag register and the result register before
// it is driven on done_o/allowed_o. Reset clears the stage valid bits and sets
// the rule to public only. The receiver cannot stall, so nothing in the
// pipeline ever waits.
`timescale 1ns / 1ps
module ip_address_policy_check_core
  import ipapc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [ModeW-1:0]   mode_i,
  input  logic [V4W-1:0]     ipv4_address_i,
  input  logic [V6HalfW-1:0] ipv6_high_i,
  input  logic [V6HalfW-1:0] ipv6_low_i,
  output logic               done_o,
  output logic               allowed_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  logic [KindW-1:0]   rule_kind_q;
  logic [V4W-1:0]     rule_v4_q;
  logic [V6HalfW-1:0] rule_v6hi_q;
  logic [V6HalfW-1:0] rule_v6lo_q;

  logic               s1_valid_q;
  logic [ModeW-1:0]   s1_mode_q;
  logic [V4W-1:0]     s1_v4_q;
  logic [V6HalfW-1:0] s1_hi_q;
  logic [V6HalfW-1:0] s1_lo_q;

  addr_flags_t        s2_flags_d;
  addr_flags_t        s2_flags_q;
  logic               s2_valid_q;

  logic               allowed_d;
  logic               done_q;
  logic               allowed_q;

  // Rule registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_kind_q <= KIND_PUBLIC;
      rule_v4_q   <= '0;
      rule_v6hi_q <= '0;
      rule_v6lo_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RULE_KIND: rule_kind_q <= cfg_data_i[KindW-1:0];
        CFG_RULE_V4:   rule_v4_q   <= cfg_data_i[V4W-1:0];
        CFG_RULE_V6HI: rule_v6hi_q <= cfg_data_i;
        CFG_RULE_V6LO: rule_v6lo_q <= cfg_data_i;
        default:       rule_kind_q <= rule_kind_q;
      endcase
    end
  end

  // Pipeline always has room
  assign busy_o = 1'b0;

  // Stage 1: input word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      s1_mode_q <= mode_i;
      s1_v4_q   <= ipv4_address_i;
      s1_hi_q   <= ipv6_high_i;
      s1_lo_q   <= ipv6_low_i;
    end
  end

  // Stage 2: class flags
  ipapc_classify u_classify (
    .mode_i              (s1_mode_q),
    .ipv4_address_i      (s1_v4_q),
    .ipv6_high_i         (s1_hi_q),
    .ipv6_low_i          (s1_lo_q),
    .rule_ipv4_address_i (rule_v4_q),
    .rule_ipv6_high_i    (rule_v6hi_q),
    .rule_ipv6_low_i     (rule_v6lo_q),
    .flags_o             (s2_flags_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_flags_q <= s2_flags_d;
    end
  end

  // Stage 3: pick the verdict for the rule kind; other families reject
  always_comb begin
    allowed_d = 1'b0;
    if (s2_flags_q.is_v4) begin
      case (rule_kind_q)
        KIND_EXACT_V4: allowed_d = s2_flags_q.v4_eq;
        KIND_EXACT_V6: allowed_d = 1'b0;
        KIND_LOOPBACK: allowed_d = s2_flags_q.v4_loop;
        KIND_PRIVATE:  allowed_d = s2_flags_q.v4_ok_priv;
        default:       allowed_d = s2_flags_q.v4_pub;
      endcase
    end else if (s2_flags_q.is_v6) begin
      case (rule_kind_q)
        KIND_EXACT_V4: allowed_d = s2_flags_q.v6_map_eq;
        KIND_EXACT_V6: allowed_d = s2_flags_q.v6_eq;
        KIND_LOOPBACK: allowed_d = s2_flags_q.v6_loop;
        KIND_PRIVATE:  allowed_d = s2_flags_q.v6_ok_priv;
        default:       allowed_d = s2_flags_q.v6_pub;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      allowed_q <= allowed_d;
    end
  end

  assign done_o    = done_q;
  assign allowed_o = done_q && allowed_q;

endmodule

// File: hdl/ipapc_classify.sv
// Classify stage: derives the address class flags of one word.
`timescale 1ns / 1ps
module ipapc_classify
  import ipapc_pkg::*;
(
  input  logic [ModeW-1:0]   mode_i,
  input  logic [V4W-1:0]     ipv4_address_i,
  input  logic [V6HalfW-1:0] ipv6_high_i,
  input  logic [V6HalfW-1:0] ipv6_low_i,
  input  logic [V4W-1:0]     rule_ipv4_address_i,
  input  logic [V6HalfW-1:0] rule_ipv6_high_i,
  input  logic [V6HalfW-1:0] rule_ipv6_low_i,
  output addr_flags_t        flags_o
);

  function automatic logic v4_hard(input logic [V4W-1:0] a);
    logic hit;
    hit = (a[31:24] == V4_NET_ZERO[31:24]) ||
          (a[31:22] == V4_NET_CGNAT[31:22]) ||
          (a[31:16] == V4_NET_LINK[31:16]) ||
          (a[31:17] == V4_NET_BENCH[31:17]) ||
          (a[31:29] == V4_NET_MCAST[31:29]);
    return hit;
  endfunction

  function automatic logic v4_public(input logic [V4W-1:0] a);
    logic priv;
    priv = (a[31:24] == V4_NET_TEN[31:24]) ||
           (a[31:24] == V4_NET_LOOP[31:24]) ||
           (a[31:20] == V4_NET_172[31:20]) ||
           (a[31:16] == V4_NET_192[31:16]);
    return !v4_hard(a) && !priv;
  endfunction

  logic         hi_zero;
  logic         mapped;
  logic         unspec;
  logic         loop6;
  logic         mcast6;
  logic         link6;
  logic         ula6;
  logic [V4W-1:0] map_v4;

  // IPv6 special forms
  assign hi_zero = (ipv6_high_i == '0);
  assign map_v4  = ipv6_low_i[V4W-1:0];
  assign mapped  = hi_zero && (ipv6_low_i[63:32] == V6_MAP_TAG);
  assign unspec  = hi_zero && (ipv6_low_i == '0);
  assign loop6   = hi_zero && (ipv6_low_i == 64'd1);
  assign mcast6  = (ipv6_high_i[63:56] == V6_MCAST_B0);
  assign link6   = (ipv6_high_i[63:54] == V6_LINK_TOP);
  assign ula6    = (ipv6_high_i[63:57] == V6_ULA_TOP);

  always_comb begin
    flags_o.is_v4      = (mode_i == MODE_V4);
    flags_o.is_v6      = (mode_i == MODE_V6);
    flags_o.v4_eq      = (ipv4_address_i == rule_ipv4_address_i);
    flags_o.v4_loop    = (ipv4_address_i[31:24] == V4_NET_LOOP[31:24]);
    flags_o.v4_ok_priv = !v4_hard(ipv4_address_i);
    flags_o.v4_pub     = v4_public(ipv4_address_i);
    flags_o.v6_eq      = (ipv6_high_i == rule_ipv6_high_i) &&
                         (ipv6_low_i == rule_ipv6_low_i);
    flags_o.v6_map_eq  = mapped && (map_v4 == rule_ipv4_address_i);
    flags_o.v6_loop    = loop6;
    flags_o.v6_ok_priv = !unspec && !mcast6 && !link6;
    // mapped addresses are judged by their IPv4 part
    if (mapped) begin
      flags_o.v6_pub = v4_public(map_v4);
    end else begin
      flags_o.v6_pub = !unspec && !loop6 && !mcast6 && !link6 && !ula6 &&
                       (ipv6_high_i[63:61] == V6_GUA_TOP);
    end
  end

endmodule

// File: hdl/ipapc_checker.sv
// Port-level checker for the IP address policy check core, with its bind.
`timescale 1ns / 1ps
module ipapc_checker
  import ipapc_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic [ModeW-1:0]   mode_i,
  input logic               done_o,
  input logic               allowed_o
);

  // a word is taken every cycle
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o) else $error("busy raised");

  // every accepted word gets its verdict
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##3 done_o) else $error("verdict missing");

  // no verdict without an earlier word
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 3)) else $error("verdict without word");

  // unknown family is always rejected
  a_other_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && mode_i != MODE_V4 && mode_i != MODE_V6
    |-> ##3 !allowed_o) else $error("other family allowed");

  // allowed only marks a strobed verdict
  a_allowed_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    allowed_o |-> done_o) else $error("allowed without done");

endmodule

bind ip_address_policy_check_core ipapc_checker u_ipapc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start_i   (start_i),
  .busy_o    (busy_o),
  .mode_i    (mode_i),
  .done_o    (done_o),
  .allowed_o (allowed_o)
);
